// ===== rtl/ecef_enu_frame_rotator_core_assert.svh =====
// Assertion macros for the frame rotator checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ECEF_ENU_FRAME_ROTATOR_CORE_ASSERT_SVH
`define ECEF_ENU_FRAME_ROTATOR_CORE_ASSERT_SVH

// same-cycle implication, held off while in reset
`define EFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while in reset
`define EFR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/efr_pkg.sv =====
// Shared types and constants for the ECEF/ENU frame rotator.
// No dependencies; imported by every module of the block except the checker.
`default_nettype none

package efr_pkg;

    // Q40 series values stay below 2^41
    localparam int VAL_W = 41;
    typedef logic [VAL_W-1:0] val_t;

    localparam val_t PIH_Q40 = 41'h1921FB54443;
    localparam val_t ONE_Q40 = 41'h10000000000;

    // Q2.30 sine / cosine
    localparam int SC_W = 32;
    typedef logic signed [SC_W-1:0] sc_t;

    localparam int TERMS    = 7;
    localparam int CELL_LAT = 5;
    // front, t, t^2, term cells, finish
    localparam int SC_LAT   = 1 + 2 + 2 + TERMS * CELL_LAT + 1;

    localparam logic FUNC_TO_ENU  = 1'b0;
    localparam logic FUNC_TO_ECEF = 1'b1;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/efr_mulq.sv =====
// Two-stage Q40 multiply with split rounding of the low partial product.
// Depends on efr_pkg.
`default_nettype none

module efr_mulq (
    input  logic          clk,
    input  logic          en,
    input  efr_pkg::val_t a,
    input  efr_pkg::val_t b,
    output efr_pkg::val_t p
);
    import efr_pkg::*;

    localparam int HB    = VAL_W - 20;
    localparam int PH_W  = VAL_W + HB;
    localparam int PL_W  = VAL_W + 20;
    localparam int PLS_W = PL_W + 1;
    localparam int SUM_W = PH_W + 1;

    logic [PH_W-1:0]  ph_reg;
    logic [PL_W-1:0]  pl_reg;
    logic [PH_W-1:0]  ph_next;
    logic [PL_W-1:0]  pl_next;
    logic [PLS_W-1:0] pl_sum;
    logic [SUM_W-1:0] sum;
    val_t             p_reg;
    val_t             p_next;

    assign ph_next = PH_W'(a) * PH_W'(b[VAL_W-1:20]);
    assign pl_next = PL_W'(a) * PL_W'(b[19:0]);

    // rnd20 on the low product, then on the total
    assign pl_sum = PLS_W'(pl_reg) + PLS_W'(20'h80000);
    assign sum    = SUM_W'(ph_reg) + SUM_W'(pl_sum[PLS_W-1:20]) + SUM_W'(20'h80000);
    assign p_next = sum[20 +: VAL_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== rtl/efr_term_cell.sv =====
// One Taylor step: term * t^2 / DIVISOR, added to or taken from the running sum.
// Depends on efr_pkg and efr_mulq.
`default_nettype none

module efr_term_cell #(
    parameter int DIVISOR = 6,
    parameter bit NEG     = 1'b1
) (
    input  logic          clk,
    input  logic          en,
    input  efr_pkg::val_t term_in,
    input  efr_pkg::val_t sum_in,
    input  efr_pkg::val_t t2_in,
    output efr_pkg::val_t term_out,
    output efr_pkg::val_t sum_out,
    output efr_pkg::val_t t2_out
);
    import efr_pkg::*;

    localparam int LW    = 21;
    localparam int HW    = VAL_W - LW;
    localparam int MH_W  = HW + VAL_W;
    localparam int ML_W  = LW + VAL_W;
    localparam int ACC_W = 2 * VAL_W + 1;
    // floor(2^41 / d): quotient estimate is exact or one low
    localparam val_t RECIP = VAL_W'((64'd1 << VAL_W) / DIVISOR);
    localparam val_t DIV_V = VAL_W'(DIVISOR);

    val_t             prod;
    logic [MH_W-1:0]  mh_reg;
    logic [ML_W-1:0]  ml_reg;
    val_t             p1_reg;
    val_t             p2_reg;
    val_t             q0_reg;
    logic [ACC_W-1:0] acc;
    val_t             qd;
    val_t             rem;
    val_t             quo;
    val_t             sum_d [0:CELL_LAT-2];
    val_t             t2_d  [0:CELL_LAT-1];
    val_t             term_reg;
    val_t             sum_reg;
    val_t             sum_next;

    efr_mulq u_mul (
        .clk (clk),
        .en  (en),
        .a   (term_in),
        .b   (t2_in),
        .p   (prod)
    );

    assign acc = (ACC_W'(mh_reg) << LW) + ACC_W'(ml_reg);
    assign qd  = VAL_W'(q0_reg * DIV_V);
    assign rem = p2_reg - qd;
    assign quo = q0_reg + VAL_W'(rem >= DIV_V);

    assign sum_next = NEG ? (sum_d[CELL_LAT-2] - quo) : (sum_d[CELL_LAT-2] + quo);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mh_reg   <= MH_W'(prod[VAL_W-1:LW]) * MH_W'(RECIP);
            ml_reg   <= ML_W'(prod[LW-1:0]) * ML_W'(RECIP);
            p1_reg   <= prod;
            q0_reg   <= acc[VAL_W +: VAL_W];
            p2_reg   <= p1_reg;
            term_reg <= quo;
            sum_reg  <= sum_next;
            sum_d[0] <= sum_in;
            t2_d[0]  <= t2_in;
            for (int i = 1; i < CELL_LAT - 1; i++)
            begin
                sum_d[i] <= sum_d[i-1];
            end
            for (int i = 1; i < CELL_LAT; i++)
            begin
                t2_d[i] <= t2_d[i-1];
            end
        end
    end

    assign term_out = term_reg;
    assign sum_out  = sum_reg;
    assign t2_out   = t2_d[CELL_LAT-1];

endmodule

`default_nettype wire

// ===== rtl/efr_sincos.sv =====
// Sine and cosine of a binary angle in Q2.30: octant fold, Taylor cell chains, unfold.
// Depends on efr_pkg, efr_mulq and efr_term_cell.
`default_nettype none

module efr_sincos #(
    parameter int ANGLE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output efr_pkg::sc_t          sin_val,
    output efr_pkg::sc_t          cos_val
);
    import efr_pkg::*;

    localparam int QS_LEN = SC_LAT - 1;
    localparam logic [30:0] QUARTER = 31'h40000000;
    localparam logic [29:0] EIGHTH  = 30'h20000000;

    logic [31:0] u;
    logic [29:0] x;
    logic        swap;
    logic [30:0] y_full;
    logic [29:0] y_reg;
    logic [2:0]  qs_line [0:QS_LEN-1];
    val_t        t;
    val_t        t2;
    val_t        t_d [0:1];

    val_t sin_term [0:TERMS];
    val_t sin_sum  [0:TERMS];
    val_t sin_t2   [0:TERMS];
    val_t cos_term [0:TERMS];
    val_t cos_sum  [0:TERMS];
    val_t cos_t2   [0:TERMS];

    logic [VAL_W:0] s_rnd;
    logic [VAL_W:0] c_rnd;
    sc_t            s_oct;
    sc_t            c_oct;
    sc_t            oa;
    sc_t            ob;
    sc_t            sin_next;
    sc_t            cos_next;
    sc_t            sin_reg;
    sc_t            cos_reg;

    // fold the angle into the first octant
    assign u      = 32'(angle) << (32 - ANGLE_BITS);
    assign x      = u[29:0];
    assign swap   = (x > EIGHTH);
    assign y_full = QUARTER - {1'b0, x};

    efr_mulq u_mul_t (
        .clk (clk),
        .en  (en),
        .a   (VAL_W'({y_reg, 10'b0})),
        .b   (PIH_Q40),
        .p   (t)
    );

    efr_mulq u_mul_t2 (
        .clk (clk),
        .en  (en),
        .a   (t),
        .b   (t),
        .p   (t2)
    );

    assign sin_term[0] = t_d[1];
    assign sin_sum[0]  = t_d[1];
    assign sin_t2[0]   = t2;
    assign cos_term[0] = ONE_Q40;
    assign cos_sum[0]  = ONE_Q40;
    assign cos_t2[0]   = t2;

    for (genvar k = 0; k < TERMS; k++)
    begin : g_term
        efr_term_cell #(
            .DIVISOR ((2 * k + 2) * (2 * k + 3)),
            .NEG     ((k % 2) == 0)
        ) u_sin_cell (
            .clk      (clk),
            .en       (en),
            .term_in  (sin_term[k]),
            .sum_in   (sin_sum[k]),
            .t2_in    (sin_t2[k]),
            .term_out (sin_term[k+1]),
            .sum_out  (sin_sum[k+1]),
            .t2_out   (sin_t2[k+1])
        );

        efr_term_cell #(
            .DIVISOR ((2 * k + 1) * (2 * k + 2)),
            .NEG     ((k % 2) == 0)
        ) u_cos_cell (
            .clk      (clk),
            .en       (en),
            .term_in  (cos_term[k]),
            .sum_in   (cos_sum[k]),
            .t2_in    (cos_t2[k]),
            .term_out (cos_term[k+1]),
            .sum_out  (cos_sum[k+1]),
            .t2_out   (cos_t2[k+1])
        );
    end

    // Q40 -> Q2.30, then unfold octant and quadrant
    assign s_rnd = {1'b0, sin_sum[TERMS]} + (VAL_W+1)'(512);
    assign c_rnd = {1'b0, cos_sum[TERMS]} + (VAL_W+1)'(512);
    assign s_oct = sc_t'(s_rnd[VAL_W:10]);
    assign c_oct = sc_t'(c_rnd[VAL_W:10]);

    always_comb
    begin
        if (qs_line[QS_LEN-1][0])
        begin
            oa = c_oct;
            ob = s_oct;
        end
        else
        begin
            oa = s_oct;
            ob = c_oct;
        end
        case (qs_line[QS_LEN-1][2:1])
            QUAD_I:
            begin
                sin_next = oa;
                cos_next = ob;
            end
            QUAD_II:
            begin
                sin_next = ob;
                cos_next = -oa;
            end
            QUAD_III:
            begin
                sin_next = -oa;
                cos_next = -ob;
            end
            default:
            begin
                sin_next = -ob;
                cos_next = oa;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg      <= swap ? y_full[29:0] : x;
            qs_line[0] <= {u[31:30], swap};
            for (int i = 1; i < QS_LEN; i++)
            begin
                qs_line[i] <= qs_line[i-1];
            end
            t_d[0]  <= t;
            t_d[1]  <= t_d[0];
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

`default_nettype wire

// ===== rtl/ecef_enu_frame_rotator_core.sv =====
// ECEF / ENU frame rotator, top level. Takes one beat per clock cycle while src_stall
// is low, and returns each result through 47 pipeline stages plus the output register.
// The latency is set by the sine/cosine Taylor chains: seven term cells of five stages
// each, run side by side for sine and cosine of both angles. Beat order is kept. The
// output register parts the two channels: while a result waits on dst_stall the pipeline
// keeps taking beats until its last stage is full, and only then raises src_stall.
// Depends on efr_pkg, efr_sincos (with efr_term_cell, efr_mulq).
`default_nettype none

module ecef_enu_frame_rotator_core #(
    parameter int ANGLE_BITS = 32,
    parameter int COMP_BITS  = 40
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         src_valid,
    output logic                         src_stall,
    input  logic                         func,
    input  logic signed [ANGLE_BITS-1:0] lat_angle,
    input  logic signed [ANGLE_BITS-1:0] lon_angle,
    input  logic signed [COMP_BITS-1:0]  comp_a,
    input  logic signed [COMP_BITS-1:0]  comp_b,
    input  logic signed [COMP_BITS-1:0]  comp_c,
    output logic                         dst_valid,
    input  logic                         dst_stall,
    output logic signed [COMP_BITS-1:0]  out_a,
    output logic signed [COMP_BITS-1:0]  out_b,
    output logic signed [COMP_BITS-1:0]  out_c,
    output logic                         saturated
);
    import efr_pkg::*;

    // stage map: 1 input, 2..42 sincos, 43 angle products, 44 matrix,
    // 45 partial products, 46 sums, 47 clamp
    localparam int PIPE_LEN = SC_LAT + 6;
    localparam int SB_LEN   = SC_LAT + 3;
    localparam int FUNC_TAP = SC_LAT + 1;
    localparam int COMP_TAP = SB_LEN - 1;

    // component split for the dot products
    localparam int LO_W = COMP_BITS / 2;
    localparam int HI_W = COMP_BITS - LO_W;
    localparam int PH_W = SC_W + HI_W;
    localparam int PL_W = SC_W + LO_W + 1;
    localparam int SH_W = PH_W + 2;
    localparam int SL_W = PL_W + 2;
    localparam int TW   = SC_W + COMP_BITS + 3;
    localparam int RW   = TW - 30;

    localparam logic signed [RW-1:0] R_MAX =
        RW'({1'b0, {(COMP_BITS-1){1'b1}}});
    localparam logic signed [RW-1:0] R_MIN =
        RW'(signed'({1'b1, {(COMP_BITS-1){1'b0}}}));

    // handshake
    logic [PIPE_LEN-1:0] vld_reg;
    logic                last_valid;
    logic                load_out;
    logic                en;
    logic                dst_valid_reg;

    // side band line
    logic                 func_line [0:SB_LEN-1];
    logic [COMP_BITS-1:0] comp_line [0:SB_LEN-1][0:2];

    logic [ANGLE_BITS-1:0] lat_reg;
    logic [ANGLE_BITS-1:0] lon_reg;

    sc_t sl;
    sc_t cl;
    sc_t so;
    sc_t co;
    sc_t sl_reg;
    sc_t cl_reg;
    sc_t so_reg;
    sc_t co_reg;
    logic signed [2*SC_W-1:0] slco_reg;
    logic signed [2*SC_W-1:0] slso_reg;
    logic signed [2*SC_W-1:0] clco_reg;
    logic signed [2*SC_W-1:0] clso_reg;

    sc_t m_next [0:8];
    sc_t m_reg  [0:8];

    logic signed [PH_W-1:0] ph_next [0:8];
    logic signed [PL_W-1:0] pl_next [0:8];
    logic signed [PH_W-1:0] ph_reg  [0:8];
    logic signed [PL_W-1:0] pl_reg  [0:8];

    logic signed [RW-1:0] r_next [0:2];
    logic signed [RW-1:0] r_reg  [0:2];

    logic signed [COMP_BITS-1:0] res_next [0:2];
    logic signed [COMP_BITS-1:0] res_reg  [0:2];
    logic                        sat_next;
    logic                        sat_reg;

    logic signed [COMP_BITS-1:0] out_a_reg;
    logic signed [COMP_BITS-1:0] out_b_reg;
    logic signed [COMP_BITS-1:0] out_c_reg;
    logic                        saturated_reg;

    // The whole pipe steps together; it only halts when the last stage holds a
    // result that the output register cannot take.
    assign last_valid = vld_reg[PIPE_LEN-1];
    assign load_out   = last_valid && (!dst_valid_reg || !dst_stall);
    assign en         = !last_valid || load_out;
    assign src_stall  = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[PIPE_LEN-2:0], src_valid};
            end
            if (load_out)
            begin
                dst_valid_reg <= 1'b1;
            end
            else if (!dst_stall)
            begin
                dst_valid_reg <= 1'b0;
            end
        end
    end

    // Sine / cosine of latitude and longitude
    efr_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sc_lat (
        .clk     (clk),
        .en      (en),
        .angle   (lat_reg),
        .sin_val (sl),
        .cos_val (cl)
    );

    efr_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sc_lon (
        .clk     (clk),
        .en      (en),
        .angle   (lon_reg),
        .sin_val (so),
        .cos_val (co)
    );

    // Matrix entries: round the angle products back to Q2.30 and pick the
    // forward or transposed layout.
    always_comb
    begin
        logic signed [2*SC_W-1:0] rnd_slco;
        logic signed [2*SC_W-1:0] rnd_slso;
        logic signed [2*SC_W-1:0] rnd_clco;
        logic signed [2*SC_W-1:0] rnd_clso;
        sc_t e_slco;
        sc_t e_slso;
        sc_t e_clco;
        sc_t e_clso;

        rnd_slco = slco_reg + (2*SC_W)'(64'sd536870912);
        rnd_slso = slso_reg + (2*SC_W)'(64'sd536870912);
        rnd_clco = clco_reg + (2*SC_W)'(64'sd536870912);
        rnd_clso = clso_reg + (2*SC_W)'(64'sd536870912);
        e_slco   = sc_t'(rnd_slco[30 +: SC_W]);
        e_slso   = sc_t'(rnd_slso[30 +: SC_W]);
        e_clco   = sc_t'(rnd_clco[30 +: SC_W]);
        e_clso   = sc_t'(rnd_clso[30 +: SC_W]);

        if (func_line[FUNC_TAP] == FUNC_TO_ECEF)
        begin
            m_next[0] = -so_reg;
            m_next[1] = -e_slco;
            m_next[2] = e_clco;
            m_next[3] = co_reg;
            m_next[4] = -e_slso;
            m_next[5] = e_clso;
            m_next[6] = '0;
            m_next[7] = cl_reg;
            m_next[8] = sl_reg;
        end
        else
        begin
            m_next[0] = -so_reg;
            m_next[1] = co_reg;
            m_next[2] = '0;
            m_next[3] = -e_slco;
            m_next[4] = -e_slso;
            m_next[5] = cl_reg;
            m_next[6] = e_clco;
            m_next[7] = e_clso;
            m_next[8] = sl_reg;
        end
    end

    // Partial products: each component split into a signed high part and an
    // unsigned low part, so no multiplier runs the full component width.
    always_comb
    begin
        logic signed [HI_W-1:0] v_hi;
        logic signed [LO_W:0]   v_lo;

        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                v_hi = signed'(comp_line[COMP_TAP][j][COMP_BITS-1:LO_W]);
                v_lo = signed'({1'b0, comp_line[COMP_TAP][j][LO_W-1:0]});
                ph_next[3*i+j] = PH_W'(m_reg[3*i+j]) * PH_W'(v_hi);
                pl_next[3*i+j] = PL_W'(m_reg[3*i+j]) * PL_W'(v_lo);
            end
        end
    end

    // Exact three-term sum, rounded half up to the component LSB
    always_comb
    begin
        logic signed [SH_W-1:0] shi;
        logic signed [SL_W-1:0] slo;
        logic signed [TW-1:0]   tot;

        for (int i = 0; i < 3; i++)
        begin
            shi = SH_W'(ph_reg[3*i]) + SH_W'(ph_reg[3*i+1]) + SH_W'(ph_reg[3*i+2]);
            slo = SL_W'(pl_reg[3*i]) + SL_W'(pl_reg[3*i+1]) + SL_W'(pl_reg[3*i+2]);
            tot = (TW'(shi) <<< LO_W) + TW'(slo) + TW'(64'sd536870912);
            r_next[i] = tot[TW-1:30];
        end
    end

    // Clamp to the component range
    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (r_reg[i] > R_MAX)
            begin
                res_next[i] = R_MAX[COMP_BITS-1:0];
                sat_next    = 1'b1;
            end
            else if (r_reg[i] < R_MIN)
            begin
                res_next[i] = R_MIN[COMP_BITS-1:0];
                sat_next    = 1'b1;
            end
            else
            begin
                res_next[i] = r_reg[i][COMP_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat_reg         <= lat_angle;
            lon_reg         <= lon_angle;
            func_line[0]    <= func;
            comp_line[0][0] <= comp_a;
            comp_line[0][1] <= comp_b;
            comp_line[0][2] <= comp_c;
            for (int i = 1; i < SB_LEN; i++)
            begin
                func_line[i] <= func_line[i-1];
                comp_line[i] <= comp_line[i-1];
            end

            sl_reg   <= sl;
            cl_reg   <= cl;
            so_reg   <= so;
            co_reg   <= co;
            slco_reg <= (2*SC_W)'(sl) * (2*SC_W)'(co);
            slso_reg <= (2*SC_W)'(sl) * (2*SC_W)'(so);
            clco_reg <= (2*SC_W)'(cl) * (2*SC_W)'(co);
            clso_reg <= (2*SC_W)'(cl) * (2*SC_W)'(so);

            m_reg  <= m_next;
            ph_reg <= ph_next;
            pl_reg <= pl_next;
            r_reg  <= r_next;

            res_reg <= res_next;
            sat_reg <= sat_next;
        end
        if (load_out)
        begin
            out_a_reg     <= res_reg[0];
            out_b_reg     <= res_reg[1];
            out_c_reg     <= res_reg[2];
            saturated_reg <= sat_reg;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign out_a     = out_a_reg;
    assign out_b     = out_b_reg;
    assign out_c     = out_c_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire

// ===== rtl/efr_checker.sv =====
// Port-level checks for the frame rotator, bound to the top level.
// Depends on ecef_enu_frame_rotator_core_assert.svh.
`default_nettype none

module efr_checker #(
    parameter int COMP_BITS = 40
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        src_stall,
    input logic                        dst_valid,
    input logic                        dst_stall,
    input logic signed [COMP_BITS-1:0] out_a,
    input logic signed [COMP_BITS-1:0] out_b,
    input logic signed [COMP_BITS-1:0] out_c,
    input logic                        saturated
);
`include "ecef_enu_frame_rotator_core_assert.svh"

    localparam logic signed [COMP_BITS-1:0] C_MAX = {1'b0, {(COMP_BITS-1){1'b1}}};
    localparam logic signed [COMP_BITS-1:0] C_MIN = {1'b1, {(COMP_BITS-1){1'b0}}};

    // a stalled result stays
    `EFR_ASSERT_NXT(a_dst_hold, dst_valid && dst_stall, dst_valid, "result beat dropped")
    `EFR_ASSERT_NXT(a_dst_stable, dst_valid && dst_stall, $stable(out_a) && $stable(out_b) && $stable(out_c) && $stable(saturated), "stalled result changed")

    // input only backs up behind a held result
    `EFR_ASSERT_IMP(a_src_stall_cause, src_stall, dst_valid && dst_stall, "input stalled without output back-pressure")

    // a clip flag needs a component at a range limit
    `EFR_ASSERT_IMP(a_sat_limit, dst_valid && saturated, out_a == C_MAX || out_a == C_MIN || out_b == C_MAX || out_b == C_MIN || out_c == C_MAX || out_c == C_MIN, "saturated set with no clipped component")

endmodule

bind ecef_enu_frame_rotator_core efr_checker #(
    .COMP_BITS (COMP_BITS)
) u_efr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_stall (src_stall),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .out_a     (out_a),
    .out_b     (out_b),
    .out_c     (out_c),
    .saturated (saturated)
);

`default_nettype wire

// ===== tb/sv/ecef_enu_frame_rotator_core_tb.sv =====
// Testbench for ecef_enu_frame_rotator_core: directed and random vectors checked
// against a bit-exact rotation predictor held in a small scoreboard class.
// Depends on efr_pkg and the rotator RTL.
`timescale 1ns / 1ps

module ecef_enu_frame_rotator_core_tb;
    import efr_pkg::*;

    localparam int AW = 32;
    localparam int CW = 40;
    localparam int RANDOM_BEATS = 1830;
    localparam int HOLD_CYCLES = 300;       // long receiver hold-off, fills the pipe
    localparam int DRAIN_CYCLES = 60;       // pipeline is 48 deep
    localparam int WATCHDOG_LIMIT = 4000;   // idle cycles before we give up

    typedef logic signed [CW-1:0] comp_t;
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        comp_t east_or_x;
        comp_t north_or_y;
        comp_t up_or_z;
        logic  clipped;
    } rotated_vec_t;

    // ------------------------------------------------------------------
    // Scoreboard: predicts the rotated vector for each beat taken and
    // checks each result beat against the oldest prediction.
    // ------------------------------------------------------------------
    class rotation_board;
        rotated_vec_t pending_vecs[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function logic [63:0] rnd20(logic [63:0] v);
            return (v + 64'h80000) >> 20;
        endfunction

        // Q40 product, split multiply as the hardware does
        static function logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
            logic [63:0] hi_part;
            logic [63:0] lo_part;
            hi_part = a * (b >> 20);
            lo_part = a * (b & 64'hFFFFF);
            return rnd20(hi_part + rnd20(lo_part));
        endfunction

        // Taylor series over the first octant, returns Q2.30
        static function void octant_sc(logic [63:0] y, output longint s, output longint c);
            logic [63:0] t, t2, ts, tc, ss, sc;
            t  = mulq(y << 10, 64'(PIH_Q40));
            t2 = mulq(t, t);
            ts = t;
            ss = t;
            tc = 64'(ONE_Q40);
            sc = 64'(ONE_Q40);
            for (int k = 1; k <= 7; k++)
            begin
                ts = mulq(ts, t2) / 64'((2 * k) * (2 * k + 1));
                tc = mulq(tc, t2) / 64'((2 * k - 1) * (2 * k));
                if (k % 2 == 1)
                begin
                    ss = ss - ts;
                    sc = sc - tc;
                end
                else
                begin
                    ss = ss + ts;
                    sc = sc + tc;
                end
            end
            s = longint'((ss + 64'd512) >> 10);
            c = longint'((sc + 64'd512) >> 10);
        endfunction

        static function void angle_sc(logic [AW-1:0] ang, output longint s, output longint c);
            logic [31:0] u;
            logic [63:0] x;
            longint a, b;
            u = 32'(ang) << (32 - AW);
            x = {34'd0, u[29:0]};
            if (x <= 64'd1 << 29)
                octant_sc(x, a, b);
            else
                octant_sc((64'd1 << 30) - x, b, a);
            case (u[31:30])
                QUAD_I:   begin s = a;  c = b;  end
                QUAD_II:  begin s = b;  c = -a; end
                QUAD_III: begin s = -a; c = -b; end
                default:  begin s = -b; c = a;  end
            endcase
        endfunction

        static function longint q30_product(longint a, longint b);
            return (a * b + (longint'(1) << 29)) >>> 30;
        endfunction

        // exact three-term sum, round half up, clamp to the component range
        static function comp_t row_dot(longint m0, longint m1, longint m2,
                                       comp_t v0, comp_t v1, comp_t v2, inout logic clip);
            wide_t acc;
            wide_t top;
            wide_t bot;
            top = (wide_t'(1) <<< (CW - 1)) - 1;
            bot = -(wide_t'(1) <<< (CW - 1));
            acc = wide_t'(m0) * wide_t'(v0) + wide_t'(m1) * wide_t'(v1)
                + wide_t'(m2) * wide_t'(v2);
            acc = (acc + (wide_t'(1) <<< 29)) >>> 30;
            if (acc > top)
            begin
                acc = top;
                clip = 1'b1;
            end
            else if (acc < bot)
            begin
                acc = bot;
                clip = 1'b1;
            end
            return comp_t'(acc);
        endfunction

        function void note_beat(logic fn, logic [AW-1:0] lat, logic [AW-1:0] lon,
                                comp_t va, comp_t vb, comp_t vc);
            longint sl, cl, so, co, slco, slso, clco, clso;
            longint m[3][3];
            rotated_vec_t r;
            logic clip;
            angle_sc(lat, sl, cl);
            angle_sc(lon, so, co);
            slco = q30_product(sl, co);
            slso = q30_product(sl, so);
            clco = q30_product(cl, co);
            clso = q30_product(cl, so);
            if (fn == FUNC_TO_ENU)
            begin
                m[0][0] = -so;   m[0][1] = co;    m[0][2] = 0;
                m[1][0] = -slco; m[1][1] = -slso; m[1][2] = cl;
                m[2][0] = clco;  m[2][1] = clso;  m[2][2] = sl;
            end
            else
            begin
                m[0][0] = -so;   m[0][1] = -slco; m[0][2] = clco;
                m[1][0] = co;    m[1][1] = -slso; m[1][2] = clso;
                m[2][0] = 0;     m[2][1] = cl;    m[2][2] = sl;
            end
            clip = 1'b0;
            r.east_or_x  = row_dot(m[0][0], m[0][1], m[0][2], va, vb, vc, clip);
            r.north_or_y = row_dot(m[1][0], m[1][1], m[1][2], va, vb, vc, clip);
            r.up_or_z    = row_dot(m[2][0], m[2][1], m[2][2], va, vb, vc, clip);
            r.clipped    = clip;
            pending_vecs.push_back(r);
        endfunction

        function int pending();
            return pending_vecs.size();
        endfunction

        task report(string what, logic [CW-1:0] got, logic [CW-1:0] want);
            $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task check_result(comp_t ra, comp_t rb, comp_t rc, logic sat);
            rotated_vec_t w;
            if (pending_vecs.size() == 0)
            begin
                report("unexpected result beat", ra, '0);
                return;
            end
            w = pending_vecs.pop_front();
            if (ra !== w.east_or_x)
                report("out_a", ra, w.east_or_x);
            if (rb !== w.north_or_y)
                report("out_b", rb, w.north_or_y);
            if (rc !== w.up_or_z)
                report("out_c", rc, w.up_or_z);
            if (sat !== w.clipped)
                report("saturated", CW'(sat), CW'(w.clipped));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;
    logic src_valid;
    logic src_stall;
    logic func;
    logic signed [AW-1:0] lat_angle;
    logic signed [AW-1:0] lon_angle;
    comp_t comp_a, comp_b, comp_c;
    logic dst_valid;
    logic dst_stall;
    comp_t out_a, out_b, out_c;
    logic saturated;

    ecef_enu_frame_rotator_core #(
        .ANGLE_BITS(AW),
        .COMP_BITS (CW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .func     (func),
        .lat_angle(lat_angle),
        .lon_angle(lon_angle),
        .comp_a   (comp_a),
        .comp_b   (comp_b),
        .comp_c   (comp_c),
        .dst_valid(dst_valid),
        .dst_stall(dst_stall),
        .out_a    (out_a),
        .out_b    (out_b),
        .out_c    (out_c),
        .saturated(saturated)
    );

    rotation_board board = new();

    bit long_hold_req = 0;  // main asks the receiver for a long hold-off
    int idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver: checks each result beat, stalls on its own pattern.
    // Samples at the edge, before the DUT's nonblocking updates land.
    // ------------------------------------------------------------------
    initial
    begin
        int stall_mode;
        int mode_left;
        int hold_left;
        stall_mode = 0;
        mode_left = 0;
        hold_left = 0;
        dst_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && dst_valid && !dst_stall)
                board.check_result(out_a, out_b, out_c, saturated);
            if (long_hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                long_hold_req = 0;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                dst_stall <= 1'b1;
            end
            else
                case (stall_mode)
                    0: dst_stall <= 1'b0;                        // free flow
                    1: dst_stall <= ($urandom_range(0, 3) == 0);
                    2: dst_stall <= ($urandom_range(0, 3) != 0);
                    default: dst_stall <= mode_left[0];          // alternates stall and flow
                endcase
        end
    end

    // Watchdog: idle means no beat moved on either channel
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // drive one beat and hold it until taken; valid stays high afterwards
    task automatic send_beat(logic fn, logic [AW-1:0] lat, logic [AW-1:0] lon,
                             comp_t va, comp_t vb, comp_t vc);
        src_valid <= 1'b1;
        func      <= fn;
        lat_angle <= lat;
        lon_angle <= lon;
        comp_a    <= va;
        comp_b    <= vb;
        comp_c    <= vc;
        do
            @(posedge clk);
        while (src_stall);
        board.note_beat(fn, lat, lon, va, vb, vc);
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            src_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [AW-1:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return AW'($urandom_range(0, 7)) << 29 ^ AW'($urandom_range(0, 15));
            1: return (AW'($urandom_range(0, 3)) << 30) + (AW'(1) << 29)
                      + AW'($urandom_range(0, 8)) - AW'(4);   // near the octant mirror
            default: return AW'($urandom);
        endcase
    endfunction

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 5))
            0: return comp_t'({$urandom, $urandom});
            1: return comp_t'($signed($urandom_range(0, 2097151)) - 1048576);
            2: return $urandom_range(0, 1) ? comp_t'({1'b0, {(CW-1){1'b1}}}) - $urandom_range(0, 3)
                                           : comp_t'({1'b1, {(CW-1){1'b0}}}) + $urandom_range(0, 3);
            3: return comp_t'($signed({$urandom, $urandom}) >>> $urandom_range(8, 30));
            default: return comp_t'({$urandom, $urandom}) >>> 1;
        endcase
    endfunction

    localparam comp_t C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam comp_t C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [AW-1:0] A_QTR = AW'(1) << (AW - 2);   // pi/2
    localparam logic [AW-1:0] A_PI  = AW'(1) << (AW - 1);   // -pi, same as +pi
    localparam logic [AW-1:0] A_OCT = AW'(1) << (AW - 3);   // pi/4

    initial
    begin
        int sent;
        int burst_left;
        logic fn;
        rst_n     <= 1'b0;
        src_valid <= 1'b0;
        func      <= FUNC_TO_ENU;
        lat_angle <= '0;
        lon_angle <= '0;
        comp_a    <= '0;
        comp_b    <= '0;
        comp_c    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: both directions, angle extremes and wrap, octant mirror,
        // component extremes and clipping
        for (int d = 0; d < 2; d++)
        begin
            fn = (d == 0) ? FUNC_TO_ENU : FUNC_TO_ECEF;
            send_beat(fn, '0, '0, comp_t'(1024), comp_t'(2048), comp_t'(-4096));
            send_beat(fn, A_QTR, -A_QTR, comp_t'(123456789), comp_t'(-5), comp_t'(7));
            send_beat(fn, A_PI, {1'b0, {(AW-1){1'b1}}}, C_MAX, C_MAX, C_MAX);
            send_beat(fn, A_OCT, A_OCT + 1, C_MIN, C_MIN, C_MIN);
            send_beat(fn, A_OCT - 1, -A_OCT, C_MIN, C_MAX, '0);
            send_beat(fn, A_PI + A_QTR, A_QTR + A_OCT, C_MAX, C_MIN, C_MAX);
            send_beat(fn, AW'(1), {AW{1'b1}}, '1, comp_t'(1), '0);
            send_beat(fn, A_OCT * 3, A_OCT * 5, comp_t'(-1), C_MAX, C_MIN);
            send_beat(fn, A_OCT * 7 + 1, A_OCT * 6 - 1, comp_t'(1) <<< 38,
                      -(comp_t'(1) <<< 38), comp_t'(1) <<< 38);
            send_beat(fn, A_OCT, A_OCT * 3, C_MIN, C_MAX, '0);   // first component clips in the ECEF pass
            idle_gap(1);
        end

        // random: bursts and gaps, one long receiver hold, one full drain
        sent = 0;
        burst_left = 0;
        while (sent < RANDOM_BEATS)
        begin
            if (sent == 600)
            begin
                long_hold_req = 1;
                // keep offering back to back through the hold so the pipe fills
                for (int j = 0; j < 150; j++)
                begin
                    send_beat(1'($urandom_range(0, 1)), rand_angle(), rand_angle(),
                              rand_comp(), rand_comp(), rand_comp());
                    sent++;
                end
            end
            if (sent >= 1200 && sent < 1201)
            begin
                src_valid <= 1'b0;
                while (board.pending() != 0)
                    @(posedge clk);
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
            end
            send_beat(1'($urandom_range(0, 1)), rand_angle(), rand_angle(),
                      rand_comp(), rand_comp(), rand_comp());
            burst_left--;
            sent++;
        end
        src_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/efr_pkg.sv
rtl/efr_mulq.sv
rtl/efr_term_cell.sv
rtl/efr_sincos.sv
rtl/ecef_enu_frame_rotator_core.sv
rtl/efr_checker.sv
tb/sv/ecef_enu_frame_rotator_core_tb.sv
